FILE: hw/rtl/oksa_pkg.sv
// shared types, constants and status codes of the slot allocator
package oksa_pkg;

  // field widths of the item channels
  localparam int OWNER_W   = 16;
  localparam int FUNC_W    = 32;
  localparam int ARGC_W    = 4;
  localparam int MASK_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int SLOTF_W   = 6;
  localparam int RELCNT_W  = 7;

  // default configuration of the table
  localparam int DEF_SLOT_COUNT = 64;
  localparam int DEF_MAX_ARITY  = 8;
  localparam int DEF_OWNER_BITS = 16;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // slots are reduced in groups of this size
  localparam int GRP_SIZE = 8;

  // operation codes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FLOAT_ARG = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FLOAT_RET = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

  // classified command handed from front to back
  typedef struct packed {
    logic                 is_release;
    logic [OWNER_W-1:0]   owner;
    logic [FUNC_W-1:0]    func;
    logic [ARGC_W-1:0]    arity;
    logic [STATUS_W-1:0]  status;
  } cmd_t;

endpackage

FILE: hw/rtl/oksa_if.sv
// request and response channel interfaces of the slot allocator
interface oksa_req_if import oksa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [OWNER_W-1:0]  owner_id;
  logic [FUNC_W-1:0]   function_index;
  logic [ARGC_W-1:0]   arg_count;
  logic [MASK_W-1:0]   arg_nonint_mask;
  logic                return_nonint;

  modport source (
    output valid, operation, owner_id, function_index, arg_count,
           arg_nonint_mask, return_nonint,
    input  ready
  );
  modport sink (
    input  valid, operation, owner_id, function_index, arg_count,
           arg_nonint_mask, return_nonint,
    output ready
  );
endinterface

interface oksa_rsp_if import oksa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOTF_W-1:0]   slot_index;
  logic [ARGC_W-1:0]    arity;
  logic                 reused;
  logic [RELCNT_W-1:0]  released_count;

  modport source (
    output valid, status, slot_index, arity, reused, released_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, arity, reused, released_count,
    output ready
  );
endinterface

FILE: hw/rtl/oksa_front.sv
// front end: takes request items and classifies acquire checks
module oksa_front import oksa_pkg::*; #(
  parameter int MAX_ARITY  = DEF_MAX_ARITY,
  parameter int OWNER_BITS = DEF_OWNER_BITS
) (
  oksa_req_if.sink req,
  output logic     push_valid,
  input  logic     push_ready,
  output cmd_t     push_data
);

  localparam logic [ARGC_W-1:0]  MAX_A    = ARGC_W'(MAX_ARITY);
  localparam logic [OWNER_W-1:0] OWN_MASK = (OWNER_BITS >= OWNER_W) ? {OWNER_W{1'b1}} :
                                            OWNER_W'((65'd1 << OWNER_BITS) - 65'd1);

  logic [MASK_W-1:0]   arg_live;
  logic                float_arg;
  logic [STATUS_W-1:0] chk_status;

  // handshake passes straight through to the queue
  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  // only mask bits below the argument count count
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      arg_live[i] = (ARGC_W'(i) < req.arg_count);
    end
  end
  assign float_arg = |(req.arg_nonint_mask & arg_live);

  // checks in order: arity, argument class, return class
  always_comb begin
    priority if (req.operation == OP_RELEASE) begin
      chk_status = ST_OK;
    end else if (req.arg_count > MAX_A) begin
      chk_status = ST_TOO_MANY;
    end else if (float_arg) begin
      chk_status = ST_FLOAT_ARG;
    end else if (req.return_nonint) begin
      chk_status = ST_FLOAT_RET;
    end else begin
      chk_status = ST_OK;
    end
  end

  // classified command
  always_comb begin
    push_data.is_release = (req.operation == OP_RELEASE);
    push_data.owner      = req.owner_id & OWN_MASK;
    push_data.func       = req.function_index;
    push_data.arity      = req.arg_count;
    push_data.status     = chk_status;
  end

endmodule

FILE: hw/rtl/oksa_fifo.sv
// short command queue between front and back
module oksa_fifo import oksa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/oksa_back.sv
// back end: slot table with parallel compare, group reduction and commit
module oksa_back import oksa_pkg::*; #(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cmd_t       pop_data,
  oksa_rsp_if.source rsp
);

  localparam int NGRP  = (SLOT_COUNT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD   = NGRP * GRP_SIZE;
  localparam int GI_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int LI_W  = $clog2(GRP_SIZE);
  localparam int SI_W  = GI_W + LI_W;
  localparam int GC_W  = $clog2(GRP_SIZE + 1);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]            state;
  cmd_t                  cur;
  logic [SLOT_COUNT-1:0] in_use;
  logic [OWNER_W-1:0]    slot_owner [SLOT_COUNT];
  logic [FUNC_W-1:0]     slot_func  [SLOT_COUNT];

  // compare stage
  logic [PAD-1:0] own_c, pair_c, free_c;
  logic [PAD-1:0] own_hit, pair_hit, free_vec;

  // group reduction stage
  logic            grp_pair_any_c [NGRP];
  logic [LI_W-1:0] grp_pair_idx_c [NGRP];
  logic            grp_free_any_c [NGRP];
  logic [LI_W-1:0] grp_free_idx_c [NGRP];
  logic [GC_W-1:0] grp_cnt_c      [NGRP];
  logic            grp_pair_any   [NGRP];
  logic [LI_W-1:0] grp_pair_idx   [NGRP];
  logic            grp_free_any   [NGRP];
  logic [LI_W-1:0] grp_free_idx   [NGRP];
  logic [GC_W-1:0] grp_cnt        [NGRP];

  // final combine
  logic             pair_found, free_found;
  logic [GI_W-1:0]  pair_g, free_g;
  logic [LI_W-1:0]  pair_l, free_l;
  logic [SI_W-1:0]  tgt_pair, tgt_free;
  logic [CNT_W-1:0] freed;
  logic             commit;
  logic             pop_err;
  logic             do_alloc;

  // result register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status, res_status;
  logic [SI_W-1:0]     res_slot;
  logic [SLOTF_W-1:0]  out_slot;
  logic [ARGC_W-1:0]   out_arity, res_arity;
  logic                out_reused, res_reused;
  logic [CNT_W-1:0]    res_freed;
  logic [RELCNT_W-1:0] out_freed;
  logic [15:0]         slot_wide;
  logic [15:0]         freed_wide;

  assign pop_ready = (state == S_IDLE);
  assign pop_err   = !pop_data.is_release && (pop_data.status != ST_OK);
  assign commit    = (state == S_FIN) && (!out_valid || rsp.ready);

  // per-slot match vectors, padding slots read as taken and foreign
  for (genvar i = 0; i < PAD; i++) begin : g_cmp
    if (i < SLOT_COUNT) begin : g_real
      assign own_c[i]  = in_use[i] && (slot_owner[i] == cur.owner);
      assign pair_c[i] = own_c[i] && (slot_func[i] == cur.func);
      assign free_c[i] = !in_use[i];
    end else begin : g_pad
      assign own_c[i]  = 1'b0;
      assign pair_c[i] = 1'b0;
      assign free_c[i] = 1'b0;
    end
  end

  // first hit, first free and owner count within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_pair_any_c[g] = |pair_hit[g*GRP_SIZE +: GRP_SIZE];
      grp_free_any_c[g] = |free_vec[g*GRP_SIZE +: GRP_SIZE];
      grp_pair_idx_c[g] = '0;
      grp_free_idx_c[g] = '0;
      grp_cnt_c[g]      = '0;
      for (int l = GRP_SIZE - 1; l >= 0; l--) begin
        if (pair_hit[g*GRP_SIZE + l]) begin
          grp_pair_idx_c[g] = LI_W'(l);
        end
        if (free_vec[g*GRP_SIZE + l]) begin
          grp_free_idx_c[g] = LI_W'(l);
        end
      end
      for (int l = 0; l < GRP_SIZE; l++) begin
        grp_cnt_c[g] = grp_cnt_c[g] + GC_W'(own_hit[g*GRP_SIZE + l]);
      end
    end
  end

  // combine groups: lowest group wins, counts add up
  always_comb begin
    pair_found = 1'b0;
    free_found = 1'b0;
    pair_g     = '0;
    free_g     = '0;
    pair_l     = '0;
    free_l     = '0;
    freed      = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_pair_any[g]) begin
        pair_found = 1'b1;
        pair_g     = GI_W'(g);
        pair_l     = grp_pair_idx[g];
      end
      if (grp_free_any[g]) begin
        free_found = 1'b1;
        free_g     = GI_W'(g);
        free_l     = grp_free_idx[g];
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      freed = freed + CNT_W'(grp_cnt[g]);
    end
  end
  assign tgt_pair = {pair_g, pair_l};
  assign tgt_free = {free_g, free_l};

  // result of the current command
  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_arity  = '0;
    res_reused = 1'b0;
    res_freed  = '0;
    do_alloc   = 1'b0;
    priority if (cur.is_release) begin
      res_freed = freed;
    end else if (cur.status != ST_OK) begin
      res_status = cur.status;
    end else if (pair_found) begin
      res_slot   = tgt_pair;
      res_arity  = cur.arity;
      res_reused = 1'b1;
    end else if (free_found) begin
      res_slot  = tgt_free;
      res_arity = cur.arity;
      do_alloc  = 1'b1;
    end else begin
      res_status = ST_EXHAUSTED;
    end
  end
  assign slot_wide  = 16'(res_slot);
  assign freed_wide = 16'(res_freed);

  // sequencer and stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            state <= pop_err ? S_FIN : S_CMP;
          end
        end
        S_CMP: begin
          state <= S_RED;
        end
        S_RED: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers of the stages
  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop_valid) begin
      cur <= pop_data;
    end
    if (state == S_CMP) begin
      own_hit  <= own_c;
      pair_hit <= pair_c;
      free_vec <= free_c;
    end
    if (state == S_RED) begin
      grp_pair_any <= grp_pair_any_c;
      grp_pair_idx <= grp_pair_idx_c;
      grp_free_any <= grp_free_any_c;
      grp_free_idx <= grp_free_idx_c;
      grp_cnt      <= grp_cnt_c;
    end
  end

  // occupancy bits: release clears the owner's slots, allocate sets one
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (commit) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cur.is_release && own_hit[i]) begin
          in_use[i] <= 1'b0;
        end else if (do_alloc && tgt_free == SI_W'(i)) begin
          in_use[i] <= 1'b1;
        end
      end
    end
  end

  // binding of a newly taken slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (commit && do_alloc && tgt_free == SI_W'(i)) begin
        slot_owner[i] <= cur.owner;
        slot_func[i]  <= cur.func;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= res_status;
      out_slot   <= slot_wide[SLOTF_W-1:0];
      out_arity  <= res_arity;
      out_reused <= res_reused;
      out_freed  <= freed_wide[RELCNT_W-1:0];
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.slot_index     = out_slot;
  assign rsp.arity          = out_arity;
  assign rsp.reused         = out_reused;
  assign rsp.released_count = out_freed;

endmodule

FILE: hw/rtl/owner_keyed_slot_allocator_core.sv
// top level of the owner-keyed slot allocator
// Binds (owner, function) pairs to SLOT_COUNT slots. The front end takes a request item
// in any cycle the two-entry command queue has room and classifies it (too many args,
// non-integer argument, non-integer return). The back end executes one command at a
// time: an acquire that fails a check goes through pop and result, a table operation
// through pop, parallel compare of all slots, per-group first-hit and count over groups
// of eight, and combine and commit, and the back end takes no new command until the
// current one has committed. A release frees all slots of the owner in its commit
// cycle. The result waits in an output register; the back end only stalls in its
// commit cycle while that register is still full.
module owner_keyed_slot_allocator_core import oksa_pkg::*; #(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT,
  parameter int MAX_ARITY  = DEF_MAX_ARITY,
  parameter int OWNER_BITS = DEF_OWNER_BITS
) (
  input  logic       clk,
  input  logic       rst,
  oksa_req_if.sink   req,
  oksa_rsp_if.source rsp
);

  logic q_push, q_ready, q_valid, q_pop;
  cmd_t q_in, q_out;

  // classify incoming items
  oksa_front #(
    .MAX_ARITY  (MAX_ARITY),
    .OWNER_BITS (OWNER_BITS)
  ) u_front (
    .req        (req),
    .push_valid (q_push),
    .push_ready (q_ready),
    .push_data  (q_in)
  );

  // decouple front and back
  oksa_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push),
    .push_ready (q_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_out)
  );

  // slot table engine
  oksa_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_valid),
    .pop_ready (q_pop),
    .pop_data  (q_out),
    .rsp       (rsp)
  );

  // a command left the queue only when the engine had stopped at its start state
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_valid) |=> !q_pop)
    else $error("engine took a new command right after another");

  // a reused slot is a successful acquire and frees nothing
  a_reuse_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.reused) |-> (rsp.status == ST_OK && rsp.released_count == '0))
    else $error("reused slot with bad status or release count");

  // a failed acquire carries no slot, arity or count
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |->
      (rsp.slot_index == '0 && rsp.arity == '0 && rsp.released_count == '0))
    else $error("error result carries slot data");

endmodule
